/* rtl/motor_drive_controller_assert.svh */
// Assertion macros shared by the checker.
`ifndef MOTOR_DRIVE_CONTROLLER_ASSERT_SVH
`define MOTOR_DRIVE_CONTROLLER_ASSERT_SVH

// Checked outside reset only.
`define MDC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every edge, reset included.
`define MDC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

/* rtl/mdc_pkg.sv */
package mdc_pkg;

    localparam int ErrW    = 20;
    localparam int NowW    = 32;
    localparam int DriveW  = 8;
    localparam int FiltW   = 24;
    localparam int ModeW   = 2;
    localparam int GainW   = 10;
    localparam int AlphaW  = 17;
    localparam int CfgIdxW = 2;
    localparam int CfgW    = AlphaW;
    localparam int InDataW = 56;
    localparam int OutDataW = 16;

    localparam int MulAW = 25;
    localparam int MulBW = 18;
    localparam int ProdW = MulAW + MulBW;

    localparam logic [ModeW-1:0] MODE_PWM_DIR = 2'd0;
    localparam logic [ModeW-1:0] MODE_FWD_REV = 2'd1;
    localparam logic [ModeW-1:0] MODE_AC      = 2'd2;

    localparam logic [CfgIdxW-1:0] REG_MODE  = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_GAIN  = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_ALPHA = 2'd2;

    localparam logic [AlphaW-1:0] ALPHA_ONE   = 17'd65536;
    localparam int                SPEED_LIMIT = 65280;
    localparam int                DEADBAND    = 128;
    localparam int                MIN_ERR     = 256;
    localparam int                MAX_ERR     = 5120;
    localparam int                ON_TIME_MS  = 20;
    localparam int                FILT_MAX    = 8388607;
    localparam int                FILT_MIN    = -8388608;
    localparam int                ROUND_HALF  = 32768;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPD,
        S_CLP,
        S_FLT,
        S_UPD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic signed [MulAW-1:0] a;
        logic signed [MulBW-1:0] b;
    } t_mul_op;

endpackage

/* rtl/mdc_mul.sv */
module mdc_mul
    import mdc_pkg::*;
(
    input  logic                    i_clk,
    input  t_mul_op                 i_op,
    output logic signed [ProdW-1:0] o_prod
);

    logic signed [ProdW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_op.a * i_op.b;
    end

    assign o_prod = r_prod;

endmodule

/* rtl/motor_drive_controller.sv */
// Proportional H-bridge / AC motor drive.
// Input stream (s_axis): one beat per control sample, error in degrees (Q.8)
// and a millisecond timestamp. Output stream (m_axis): one beat per sample,
// the two pin levels. Config port: write mode, gain and filter weight while
// the block is idle; index 3 is ignored.
// Steps from input beat to output valid in the pwm modes: gain multiply,
// clamp, filter multiply, filter update, output; ac mode skips the first
// two and the unused mode goes straight to output. One shared 25x18
// multiplier does the gain and filter multiplies in turn; s_axis_tready
// is high only in the idle state, so a sample waits until the last has left.
// The output beat sits in a register; if the sink stalls, the sequencer
// waits in its last step and the next sample waits for it.
// Reset: filter, pulse timer and pin levels clear; mode 0, gain 1, weight 1.0.
module motor_drive_controller
    import mdc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [InDataW-1:0]   s_axis_tdata,  // error_deg[19:0], now_ms[51:20]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OutDataW-1:0]  m_axis_tdata,  // drive_a[7:0], drive_b[15:8]
    input  logic                 i_cfg_wr_en,
    input  logic [CfgIdxW-1:0]   i_cfg_index,
    input  logic [CfgW-1:0]      i_cfg_data
);

    t_state r_state, n_state;

    logic [ModeW-1:0]         r_mode;
    logic [GainW-1:0]         r_gain;
    logic [AlphaW-1:0]        r_alpha;
    logic signed [ErrW-1:0]   r_err;
    logic [NowW-1:0]          r_now;
    logic signed [ErrW-1:0]   r_x;
    logic signed [FiltW-1:0]  r_fv;
    logic [NowW-1:0]          r_last;
    logic [DriveW-1:0]        r_held_a, r_held_b;
    logic                     r_out_valid;
    logic [OutDataW-1:0]      r_out_data;

    t_mul_op                  mul_op;
    logic signed [ProdW-1:0]  prod;
    logic                     in_acc, out_free, out_load;

    logic [AlphaW-1:0]        alpha_c;
    logic signed [MulAW-1:0]  diff;
    logic signed [ProdW-1:0]  prod_rnd;
    logic signed [FiltW+3:0]  fv_sum;
    logic signed [ErrW-1:0]   spd_clamp;

    logic [FiltW-1:0]         mag;
    logic [DriveW-1:0]        duty;
    logic                     dead, pos;
    logic [12:0]              off_diff;
    logic [15:0]              off_mul;
    logic [NowW-1:0]          off_thr, elapsed;
    logic [DriveW-1:0]        n_held_a, n_held_b;
    logic                     n_restart;

    mdc_mul u_mul (
        .i_clk  (i_clk),
        .i_op   (mul_op),
        .o_prod (prod)
    );

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_mode == MODE_PWM_DIR || r_mode == MODE_FWD_REV)
                        n_state = S_SPD;
                    else if (r_mode == MODE_AC)
                        n_state = S_FLT;
                    else
                        n_state = S_OUT;
                end
            end
            S_SPD: n_state = S_CLP;
            S_CLP: n_state = S_FLT;
            S_FLT: n_state = S_UPD;
            S_UPD: n_state = S_OUT;
            S_OUT: begin
                if (out_free)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath arithmetic
    always_comb begin
        alpha_c = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;
        diff    = MulAW'(r_x) - MulAW'(r_fv);

        mul_op.a = MulAW'(r_err);
        mul_op.b = MulBW'({8'd0, r_gain});
        if (r_state == S_FLT) begin
            mul_op.a = diff;
            mul_op.b = MulBW'({1'b0, alpha_c});
        end

        if (prod > ProdW'(SPEED_LIMIT))
            spd_clamp = ErrW'(SPEED_LIMIT);
        else if (prod < -ProdW'(SPEED_LIMIT))
            spd_clamp = -ErrW'(SPEED_LIMIT);
        else
            spd_clamp = prod[ErrW-1:0];

        // round to nearest, halves up: floor((p + 2^15) / 2^16)
        prod_rnd = prod + ProdW'(ROUND_HALF);
        fv_sum   = (FiltW+4)'(r_fv) + (FiltW+4)'($signed(prod_rnd[ProdW-1:16]));
    end

    // outputs of the sequencer
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        out_load      = (r_state == S_OUT) && out_free;

        mag  = r_fv[FiltW-1] ? FiltW'(-r_fv) : FiltW'(r_fv);
        duty = (mag[FiltW-1:16] != '0) ? '1 : mag[15:8];
        pos  = !r_fv[FiltW-1] && (r_fv != '0);
        dead = (r_err > -ErrW'(DEADBAND)) && (r_err < ErrW'(DEADBAND));

        off_diff = 13'(MAX_ERR) - mag[12:0];
        off_mul  = {1'b0, off_diff, 2'b00} + {3'b000, off_diff};
        off_thr  = 32'(ON_TIME_MS);
        if (mag <= FiltW'(MAX_ERR))
            off_thr = 32'(ON_TIME_MS) + {24'd0, off_mul[15:8]};
        elapsed = r_now - r_last;

        n_held_a  = r_held_a;
        n_held_b  = r_held_b;
        n_restart = 1'b0;
        case (r_mode)
            MODE_PWM_DIR: begin
                n_held_a = dead ? '0 : duty;
                n_held_b = DriveW'(pos);
            end
            MODE_FWD_REV: begin
                if (dead) begin
                    n_held_a = '0;
                    n_held_b = '0;
                end else if (pos) begin
                    n_held_a = duty;
                    n_held_b = '0;
                end else begin
                    n_held_a = '0;
                    n_held_b = duty;
                end
            end
            MODE_AC: begin
                if (mag >= FiltW'(MIN_ERR)) begin
                    if (elapsed > 32'(ON_TIME_MS)) begin
                        n_held_a = '0;
                        n_held_b = '0;
                    end
                    if (elapsed > off_thr) begin
                        n_restart = 1'b1;
                        if (pos)
                            n_held_a = DriveW'(1);
                        else
                            n_held_b = DriveW'(1);
                    end
                end else begin
                    n_held_a = '0;
                    n_held_b = '0;
                end
            end
            default: begin
                n_held_a = r_held_a;
                n_held_b = r_held_b;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_PWM_DIR;
            r_gain      <= GainW'(1);
            r_alpha     <= ALPHA_ONE;
            r_fv        <= '0;
            r_last      <= '0;
            r_held_a    <= '0;
            r_held_b    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_MODE:  r_mode  <= i_cfg_data[ModeW-1:0];
                    REG_GAIN:  r_gain  <= i_cfg_data[GainW-1:0];
                    REG_ALPHA: r_alpha <= i_cfg_data[AlphaW-1:0];
                    default: ;
                endcase
            end
            if (r_state == S_UPD) begin
                if (fv_sum > (FiltW+4)'(FILT_MAX))
                    r_fv <= FiltW'(FILT_MAX);
                else if (fv_sum < (FiltW+4)'(FILT_MIN))
                    r_fv <= FiltW'(FILT_MIN);
                else
                    r_fv <= fv_sum[FiltW-1:0];
            end
            if (out_load) begin
                r_held_a <= n_held_a;
                r_held_b <= n_held_b;
                if (n_restart)
                    r_last <= r_now;
            end
            if (out_load)
                r_out_valid <= 1'b1;
            else if (m_axis_tready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_err <= s_axis_tdata[ErrW-1:0];
            r_now <= s_axis_tdata[ErrW+NowW-1:ErrW];
            r_x   <= s_axis_tdata[ErrW-1:0];
        end else if (r_state == S_CLP) begin
            r_x <= spd_clamp;
        end
        if (out_load)
            r_out_data <= {n_held_b, n_held_a};
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

/* rtl/mdc_checker.sv */
`include "motor_drive_controller_assert.svh"

module mdc_checker
    import mdc_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [OutDataW-1:0] m_axis_tdata
);

    // a stalled result beat holds its value
    `MDC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output beat changed under stall")

    // one sample at a time: busy right after taking a beat
    `MDC_ASSERT(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while busy")

    // a new result only comes out of a busy period
    `MDC_ASSERT(a_result_from_work, $rose(m_axis_tvalid) |-> !$past(s_axis_tready), "result without work")

    `MDC_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule

bind motor_drive_controller mdc_checker u_mdc_checker (.*);

/* test/tb_motor_drive_controller.sv */
`timescale 1ns / 100ps

module tb_motor_drive_controller;
    import mdc_pkg::*;

    localparam logic [CfgIdxW-1:0] REG_UNUSED  = 2'd3;
    localparam logic [ModeW-1:0]   MODE_UNUSED = 2'd3;
    localparam int                 STALL_LIMIT = 5000;
    localparam int                 PAD_W       = InDataW - ErrW - NowW;

    typedef struct packed {
        logic [DriveW-1:0] drive_b;
        logic [DriveW-1:0] drive_a;
    } t_pins;

    // Mirrors the drive sequencer per sample and queues the pin levels it should emit.
    class drive_scoreboard;
        logic [ModeW-1:0]         mode;
        logic [GainW-1:0]         gain;
        logic [AlphaW-1:0]        alpha;
        logic signed [FiltW-1:0]  filt;
        logic [NowW-1:0]          pulse_start;
        logic [DriveW-1:0]        pin_a;
        logic [DriveW-1:0]        pin_b;
        t_pins                    expected_pins[$];
        int                       errors;

        function new();
            mode        = MODE_PWM_DIR;
            gain        = 1;
            alpha       = ALPHA_ONE;
            filt        = '0;
            pulse_start = '0;
            pin_a       = '0;
            pin_b       = '0;
            errors      = 0;
        endfunction

        function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
            case (idx)
                REG_MODE:  mode  = val[ModeW-1:0];
                REG_GAIN:  gain  = val[GainW-1:0];
                REG_ALPHA: alpha = val[AlphaW-1:0];
                default: ;
            endcase
        endfunction

        // y += alpha*(x-y), step rounded half up, weight capped at 1.0
        function logic signed [FiltW-1:0] smooth(longint x);
            longint a, step, y;
            a = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
            step = ((x - filt) * a + ROUND_HALF) >>> 16;
            y = filt + step;
            if (y > FILT_MAX) y = FILT_MAX;
            if (y < FILT_MIN) y = FILT_MIN;
            filt = y[FiltW-1:0];
            return filt;
        endfunction

        function logic [DriveW-1:0] duty_of(longint mag);
            return ((mag >>> 8) > 255) ? 8'd255 : mag[15:8];
        endfunction

        function void note_sample(logic signed [ErrW-1:0] e, logic [NowW-1:0] t);
            longint      err, spd, y, mag, off;
            logic [31:0] elapsed;
            bit          dead;
            t_pins       pins;
            err = e;
            case (mode)
                MODE_PWM_DIR, MODE_FWD_REV: begin
                    spd = err * longint'(gain);
                    if (spd > SPEED_LIMIT) spd = SPEED_LIMIT;
                    if (spd < -SPEED_LIMIT) spd = -SPEED_LIMIT;
                    y = smooth(spd);
                    dead = (err < DEADBAND) && (err > -DEADBAND);
                    if (mode == MODE_PWM_DIR) begin
                        pin_a = dead ? 8'd0 : duty_of(y < 0 ? -y : y);
                        pin_b = (y > 0) ? 8'd1 : 8'd0;
                    end else if (dead) begin
                        pin_a = '0;
                        pin_b = '0;
                    end else if (y > 0) begin
                        pin_a = duty_of(y);
                        pin_b = '0;
                    end else begin
                        pin_a = '0;
                        pin_b = duty_of(-y);
                    end
                end
                MODE_AC: begin
                    y = smooth(err);
                    mag = (y < 0) ? -y : y;
                    if (mag >= MIN_ERR) begin
                        off = (mag <= MAX_ERR) ? (((MAX_ERR - mag) * 5) >>> 8) : 0;
                        elapsed = t - pulse_start;
                        if (longint'(elapsed) > ON_TIME_MS) begin
                            pin_a = '0;
                            pin_b = '0;
                        end
                        if (longint'(elapsed) > ON_TIME_MS + off) begin
                            if (y <= 0) pin_b = 8'd1;
                            else pin_a = 8'd1;
                            pulse_start = t;
                        end
                    end else begin
                        pin_a = '0;
                        pin_b = '0;
                    end
                end
                default: ;  // unused mode holds everything
            endcase
            pins.drive_a = pin_a;
            pins.drive_b = pin_b;
            expected_pins.push_back(pins);
        endfunction

        function void check_drive(t_pins got);
            t_pins want;
            if (expected_pins.size() == 0) begin
                $error("unexpected output beat: drive_a %0d drive_b %0d",
                       got.drive_a, got.drive_b);
                errors++;
                return;
            end
            want = expected_pins.pop_front();
            if (got.drive_a !== want.drive_a) begin
                $error("drive_a mismatch: expected %0d, actual %0d", want.drive_a, got.drive_a);
                errors++;
            end
            if (got.drive_b !== want.drive_b) begin
                $error("drive_b mismatch: expected %0d, actual %0d", want.drive_b, got.drive_b);
                errors++;
            end
        endfunction

        function int pending();
            return expected_pins.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [InDataW-1:0]   s_axis_tdata = '0;   // error_deg[19:0], now_ms[51:20]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OutDataW-1:0]  m_axis_tdata;        // drive_a[7:0], drive_b[15:8]
    logic                 i_cfg_wr_en = 1'b0;
    logic [CfgIdxW-1:0]   i_cfg_index = '0;
    logic [CfgW-1:0]      i_cfg_data = '0;

    drive_scoreboard sb;
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    int              hold_req = 0;
    int              hold_left = 0;
    int              idle_cycles = 0;
    int              phase_no = 0;
    logic [NowW-1:0] clock_ms = '0;

    motor_drive_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // sink side: check beats, random stalls, long hold-off on request
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_drive(m_axis_tdata);
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic logic [ErrW-1:0] pwm_error();
        int v;
        case ($urandom_range(9))
            0, 1:       v = int'($urandom_range(260)) - 130;
            2, 3, 4, 5: v = int'($urandom_range(8000)) - 4000;
            6, 7:       v = $urandom;
            8: begin
                case ($urandom_range(3))
                    0:       v = 524287;
                    1:       v = -524288;
                    2:       v = DEADBAND;
                    default: v = -DEADBAND;
                endcase
            end
            default:    v = int'($urandom_range(131070)) - 65535;
        endcase
        return v[ErrW-1:0];
    endfunction

    function automatic logic [ErrW-1:0] ac_error();
        int v;
        case ($urandom_range(9))
            7:       v = int'($urandom_range(600)) - 300;
            8:       v = $urandom;
            9:       v = 0;
            default: v = int'($urandom_range(14000)) - 7000;
        endcase
        return v[ErrW-1:0];
    endfunction

    function automatic void set_profile(int n);
        case (n % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
        endcase
    endfunction

    task automatic send_sample(input logic [ErrW-1:0] e, input logic [NowW-1:0] t);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{PAD_W{1'b0}}, t, e};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(e, t);
    endtask

    // block goes idle once every beat is back; then wait on for margin
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        sb.set_reg(idx, val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [ModeW-1:0] mode, input logic [GainW-1:0] gain,
                             input logic [AlphaW-1:0] alpha, input int count,
                             input int stall);
        settle();
        set_profile(phase_no);
        phase_no++;
        cfg_write(REG_MODE, CfgW'(mode));
        cfg_write(REG_GAIN, CfgW'(gain));
        cfg_write(REG_ALPHA, alpha);
        hold_req = stall;
        repeat (count) begin
            if (mode == MODE_AC) begin
                case ($urandom_range(19))
                    0:       clock_ms = $urandom;
                    1:       clock_ms += $urandom_range(200, 46);
                    default: clock_ms += $urandom_range(45);
                endcase
                send_sample(ac_error(), clock_ms);
            end else begin
                send_sample(pwm_error(), $urandom);
            end
        end
    endtask

    initial begin
        sb = new();
        set_profile(3);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pwm + direction at reset settings: zero, deadband edges, extremes
        send_sample(0, 0);
        send_sample(127, 1);
        send_sample(-127, 2);
        send_sample(ErrW'(DEADBAND), 3);
        send_sample(ErrW'(-DEADBAND), 4);
        send_sample(524287, 5);
        send_sample(-524288, 6);
        settle();
        cfg_write(REG_GAIN, 1023);
        send_sample(100, 7);     // deadband with large speed: direction only
        send_sample(-300, 8);
        settle();
        cfg_write(REG_MODE, CfgW'(MODE_FWD_REV));
        cfg_write(REG_GAIN, 1);
        send_sample(200, 9);
        send_sample(-256, 10);
        send_sample(0, 11);      // zero error is in the deadband: both pins off
        send_sample(524287, 12);
        settle();
        // ac: pulse, hold, off time, no off time, stop, timer wrap
        cfg_write(REG_MODE, CfgW'(MODE_AC));
        send_sample(1000, 100);
        send_sample(1000, 110);
        send_sample(-1000, 125);
        send_sample(6000, 130);
        send_sample(100, 131);
        send_sample(-524288, 32'hFFFF_FFF0);
        send_sample(524287, 32'h0000_0040);
        settle();
        // frozen filter far above 255.0 saturates the duty
        cfg_write(REG_ALPHA, 0);
        cfg_write(REG_MODE, CfgW'(MODE_PWM_DIR));
        send_sample(500, 0);
        settle();
        cfg_write(REG_UNUSED, 17'h1FFFF);
        cfg_write(REG_MODE, CfgW'(MODE_UNUSED));
        send_sample(-5000, 77);

        run_phase(MODE_PWM_DIR, 1, ALPHA_ONE, 150, 0);
        run_phase(MODE_PWM_DIR, 1023, AlphaW'($urandom_range(131071)), 150, 0);
        run_phase(MODE_FWD_REV, 0, ALPHA_ONE, 100, 0);
        run_phase(MODE_FWD_REV, GainW'($urandom_range(1023)), 17'h1FFFF, 150, 300);
        run_phase(MODE_FWD_REV, 1023, 0, 50, 0);
        clock_ms = 32'hFFFF_FC00;
        run_phase(MODE_AC, GainW'($urandom_range(1023)), ALPHA_ONE, 250, 0);
        run_phase(MODE_AC, 1, AlphaW'($urandom_range(ALPHA_ONE, 8192)), 250, 0);
        run_phase(MODE_AC, 1023, 17'h1FFFF, 150, 0);
        run_phase(MODE_PWM_DIR, GainW'($urandom_range(1023)),
                  AlphaW'($urandom_range(2000, 1)), 150, 0);
        run_phase(MODE_UNUSED, GainW'($urandom_range(1023)),
                  AlphaW'($urandom_range(131071)), 30, 0);
        run_phase(MODE_FWD_REV, GainW'($urandom_range(1023)),
                  AlphaW'($urandom_range(131071)), 150, 0);
        run_phase(MODE_PWM_DIR, GainW'($urandom_range(1023)),
                  AlphaW'($urandom_range(131071)), 150, 0);

        settle();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/mdc_pkg.sv
rtl/mdc_mul.sv
rtl/motor_drive_controller.sv
rtl/mdc_checker.sv
test/tb_motor_drive_controller.sv
